@@ src/svl_pkg.sv @@
// shared constants, types and state encoding for the vector setpoint slew limiter
`timescale 1ns / 1ps

package svl_pkg;

    // angle format and field widths
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ANGLE_W         = 16;
    localparam int OP_W            = 2;
    localparam int LIMIT_W         = 15;
    localparam int INTERVAL_W      = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 1;

    // datapath widths
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int SUMSQ_W = 2 * ANGLE_W + 2;
    localparam int MUL_W   = ANGLE_W + LIMIT_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CAND_W  = 2 * LIMIT_W + SUMSQ_W + 1;
    localparam int QBIT_W  = $clog2(LIMIT_W);

    // register reset values: 0.02 rad rounded, 100 ticks
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET =
        LIMIT_W'((((1 << ANGLE_FRAC_BITS) * 2) + 50) / 100);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
    localparam logic [INTERVAL_W-1:0] TICK_MAX       = '1;

    // item opcodes
    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQ,
        S_SQACC,
        S_LIM,
        S_LIMCMP,
        S_NUM,
        S_NSQ,
        S_RSTART,
        S_ROOT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [SUMSQ_W-1:0] sumsq;
        logic [PROD_W-1:0]  numsq;
    } t_root_req;

    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] quot;
    } t_root_rsp;

endpackage

@@ src/svl_mul.sv @@
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module svl_mul import svl_pkg::*; (
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;
    logic [PROD_W-1:0] n_p;

    always_comb begin
        n_p = PROD_W'(i_a) * PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

@@ src/svl_root.sv @@
// bit-serial search for the largest q with q*q*sumsq <= numsq
`timescale 1ns / 1ps

module svl_root import svl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_root_req i_req,
    output t_root_rsp o_rsp
);

    logic               r_run, n_run;
    logic               r_ph, n_ph;
    logic               r_done, n_done;
    logic [QBIT_W-1:0]  r_k, n_k;
    logic [LIMIT_W-1:0] r_q, n_q;
    logic [CAND_W-1:0]  r_t, n_t;     // q^2 * s
    logic [CAND_W-1:0]  r_uk, n_uk;   // (q * s) << (k + 1)
    logic [CAND_W-1:0]  r_ss, n_ss;   // s << 2k
    logic [CAND_W-1:0]  r_c, n_c;     // q^2 * s + s << 2k
    logic [PROD_W-1:0]  r_nsq, n_nsq;
    logic [CAND_W-1:0]  w_cand;
    logic [CAND_W-1:0]  w_uk_add;
    logic               w_fit;

    always_comb begin
        w_cand   = r_c + r_uk;
        w_fit    = (w_cand <= CAND_W'(r_nsq));
        w_uk_add = r_uk + (r_ss << 1);

        n_run  = r_run;
        n_ph   = r_ph;
        n_done = 1'b0;
        n_k    = r_k;
        n_q    = r_q;
        n_t    = r_t;
        n_uk   = r_uk;
        n_ss   = r_ss;
        n_c    = r_c;
        n_nsq  = r_nsq;

        if (i_req.start) begin
            n_run = 1'b1;
            n_ph  = 1'b0;
            n_k   = QBIT_W'(LIMIT_W - 1);
            n_q   = '0;
            n_t   = '0;
            n_uk  = '0;
            n_ss  = CAND_W'(i_req.sumsq) << (2 * (LIMIT_W - 1));
            n_nsq = i_req.numsq;
        end else if (r_run) begin
            if (!r_ph) begin
                n_c  = r_t + r_ss;
                n_ph = 1'b1;
            end else begin
                n_ph = 1'b0;
                if (w_fit) begin
                    n_t      = w_cand;
                    n_q[r_k] = 1'b1;
                    n_uk     = w_uk_add >> 1;
                end else begin
                    n_uk = r_uk >> 1;
                end
                n_ss = r_ss >> 2;
                if (r_k == '0) begin
                    n_run  = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_k   <= n_k;
        r_q   <= n_q;
        r_t   <= n_t;
        r_uk  <= n_uk;
        r_ss  <= n_ss;
        r_c   <= n_c;
        r_nsq <= n_nsq;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

@@ src/vector_setpoint_slew_limiter_core.sv @@
// top level of the vector setpoint slew limiter: sequencer, state and handshakes
`timescale 1ns / 1ps

// usage
// - input channel: i_in_valid / o_in_stall carry one item (opcode and three target
//   angles, signed Q3.12 radians); an item is taken when valid is high and stall low
// - output channel: o_out_valid / i_out_stall carry roll and pitch of the setpoint
// - config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 step limit, 1 step interval); write only while the block is idle
// - o_in_stall is high whenever the sequencer is busy with an item
// - set target: no result; tick without a step: no result
// - reset setpoints: gives a result
// - tick that snaps to the target: gives a result
// - tick that takes a limited step: gives a result; most of its work goes into three
//   runs of the bit-serial root unit (15 quotient bits), fed
//   by one shared registered multiplier for squares and products
// - one result register sits on the output; a waiting result does not block
//   items that give no result, but a new result waits until the old one is taken
// - a stalling receiver holds the result register and its payload steady
// - reset clears setpoint, target and tick counter and loads the register
//   defaults (0.02 rad limit, 100 ticks); no result is pending after reset

module vector_setpoint_slew_limiter_core import svl_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [OP_W-1:0]               i_opcode,
    input  logic signed [ANGLE_W-1:0]     i_target_roll,
    input  logic signed [ANGLE_W-1:0]     i_target_pitch,
    input  logic signed [ANGLE_W-1:0]     i_target_yaw,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [ANGLE_W-1:0]     o_out_roll,
    output logic signed [ANGLE_W-1:0]     o_out_pitch,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // sequencer and architectural state
    t_state                 r_state, n_state;
    logic [ANGLE_W-1:0]     r_cur [3];
    logic [ANGLE_W-1:0]     n_cur [3];
    logic [ANGLE_W-1:0]     r_tgt [3];
    logic [ANGLE_W-1:0]     n_tgt [3];
    logic [INTERVAL_W-1:0]  r_elapsed, n_elapsed;
    logic [LIMIT_W-1:0]     r_limit, n_limit;
    logic [INTERVAL_W-1:0]  r_interval, n_interval;

    // per-step working registers
    logic [ANGLE_W-1:0]     r_abs [3];
    logic [ANGLE_W-1:0]     n_abs [3];
    logic [2:0]             r_neg, n_neg;
    logic [1:0]             r_ax, n_ax;
    logic [SUMSQ_W-1:0]     r_s, n_s;
    logic                   r_clr, n_clr;     // clear tick counter when emitting

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [ANGLE_W-1:0]     r_out_roll, n_out_roll;
    logic [ANGLE_W-1:0]     r_out_pitch, n_out_pitch;

    // shared units
    logic [MUL_W-1:0]       w_mul_a;
    logic [MUL_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]      w_mul_p;
    t_root_req              w_root_req;
    t_root_rsp              w_root_rsp;

    logic signed [DIFF_W-1:0] w_diff [3];
    logic                     w_same;
    logic                     w_accept;
    logic [ANGLE_W-1:0]       w_quot_ext;

    svl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    svl_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_root_req),
        .o_rsp   (w_root_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_quot_ext = ANGLE_W'(w_root_rsp.quot);

    // target minus setpoint on each axis, one bit wider
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = $signed({r_tgt[i][ANGLE_W-1], r_tgt[i]})
                      - $signed({r_cur[i][ANGLE_W-1], r_cur[i]});
        end
        w_same = (w_diff[0] == '0) && (w_diff[1] == '0) && (w_diff[2] == '0);
    end

    // multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_SQ: begin
                w_mul_a = MUL_W'(r_abs[r_ax]);
                w_mul_b = MUL_W'(r_abs[r_ax]);
            end
            S_LIM: begin
                w_mul_a = MUL_W'(r_limit);
                w_mul_b = MUL_W'(r_limit);
            end
            S_NUM: begin
                w_mul_a = MUL_W'(r_abs[r_ax]);
                w_mul_b = MUL_W'(r_limit);
            end
            S_NSQ: begin
                // product of the previous cycle is |d| * limit
                w_mul_a = w_mul_p[MUL_W-1:0];
                w_mul_b = w_mul_p[MUL_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_root_req.start = (r_state == S_RSTART);
        w_root_req.sumsq = r_s;
        w_root_req.numsq = w_mul_p;
    end

    // next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_elapsed   = r_elapsed;
        n_limit     = r_limit;
        n_interval  = r_interval;
        n_abs       = r_abs;
        n_neg       = r_neg;
        n_ax        = r_ax;
        n_s         = r_s;
        n_clr       = r_clr;
        n_out_roll  = r_out_roll;
        n_out_pitch = r_out_pitch;

        // a taken result frees the output register
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_LIMIT:    n_limit    = i_cfg_data[LIMIT_W-1:0];
                CFG_STEP_INTERVAL: n_interval = i_cfg_data[INTERVAL_W-1:0];
                default:           n_limit    = r_limit;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode)
                        OP_SET: begin
                            n_tgt[0] = i_target_roll;
                            n_tgt[1] = i_target_pitch;
                            n_tgt[2] = i_target_yaw;
                        end
                        OP_TICK: begin
                            if (r_elapsed != TICK_MAX) begin
                                n_elapsed = r_elapsed + 1'b1;
                            end
                            n_state = S_CHECK;
                        end
                        OP_ZERO: begin
                            for (int i = 0; i < 3; i++) begin
                                n_cur[i] = '0;
                                n_tgt[i] = '0;
                            end
                            n_clr   = 1'b0;
                            n_state = S_EMIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                for (int i = 0; i < 3; i++) begin
                    n_neg[i] = w_diff[i][DIFF_W-1];
                    n_abs[i] = w_diff[i][DIFF_W-1] ? ANGLE_W'(-w_diff[i])
                                                   : ANGLE_W'(w_diff[i]);
                end
                n_s  = '0;
                n_ax = '0;
                if (w_same || (r_elapsed <= r_interval)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_SQACC;
            end
            S_SQACC: begin
                // sum of squared axis distances
                n_s = r_s + SUMSQ_W'(w_mul_p[2*ANGLE_W-1:0]);
                if (r_ax == 2'd2) begin
                    n_ax    = '0;
                    n_state = S_LIM;
                end else begin
                    n_ax    = r_ax + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_LIM: begin
                n_state = S_LIMCMP;
            end
            S_LIMCMP: begin
                n_clr = 1'b1;
                if (r_s > w_mul_p[SUMSQ_W-1:0]) begin
                    n_state = S_NUM;
                end else begin
                    // within reach: snap to target
                    n_cur   = r_tgt;
                    n_state = S_EMIT;
                end
            end
            S_NUM: begin
                n_state = S_NSQ;
            end
            S_NSQ: begin
                n_state = S_RSTART;
            end
            S_RSTART: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_rsp.done) begin
                    n_cur[r_ax] = r_neg[r_ax] ? (r_cur[r_ax] - w_quot_ext)
                                              : (r_cur[r_ax] + w_quot_ext);
                    if (r_ax == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_ax    = r_ax + 1'b1;
                        n_state = S_NUM;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_roll  = r_cur[0];
                    n_out_pitch = r_cur[1];
                    if (r_clr) begin
                        n_elapsed = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_limit     <= LIMIT_RESET;
            r_interval  <= INTERVAL_RESET;
            r_clr       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_elapsed   <= n_elapsed;
            r_limit     <= n_limit;
            r_interval  <= n_interval;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
        end
        r_abs       <= n_abs;
        r_neg       <= n_neg;
        r_ax        <= n_ax;
        r_s         <= n_s;
        r_out_roll  <= n_out_roll;
        r_out_pitch <= n_out_pitch;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_roll  = r_out_roll;
    assign o_out_pitch = r_out_pitch;

endmodule
